// ===== hdl/cgs_pkg.sv =====
// cgs_pkg: shared types and constants for the six-phase crawl gait sequencer
// holds beat layouts, configuration set, phase codes and register indexes
// no dependencies
package cgs_pkg;

    localparam int LEN_W     = 16;
    localparam int PAUSE_W   = 11;
    localparam int SMIN_W    = 12;
    localparam int SMAX_W    = 13;
    localparam int STOL_W    = 11;
    localparam int TOUCH_W   = 12;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DW    = 16;
    localparam int VERT_IN   = 4;

    localparam logic [TOUCH_W-1:0] TOUCH_MAX = '1;

    localparam logic [LEN_W-1:0]   RST_PRISM_MAX = 16'd5120;
    localparam logic [LEN_W-1:0]   RST_PRISM_MIN = 16'd1280;
    localparam logic [LEN_W-1:0]   RST_STEP      = 16'd256;
    localparam logic [PAUSE_W-1:0] RST_PAUSE     = 11'd500;
    localparam logic [SMIN_W-1:0]  RST_SMIN      = 12'd1280;
    localparam logic [SMAX_W-1:0]  RST_SMAX      = 13'd2560;
    localparam logic [STOL_W-1:0]  RST_STOL      = 11'd256;

    typedef enum logic [2:0] {
        PH_EXPAND_BOTTOM  = 3'd0,
        PH_RETRACT_TOP    = 3'd1,
        PH_PUSH_TOP       = 3'd2,
        PH_EXPAND_TOP     = 3'd3,
        PH_RETRACT_BOTTOM = 3'd4,
        PH_PULL_BOTTOM    = 3'd5
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRISM_MAX  = 3'd0,
        CFG_PRISM_MIN  = 3'd1,
        CFG_STEP       = 3'd2,
        CFG_PAUSE      = 3'd3,
        CFG_STRING_MIN = 3'd4,
        CFG_STRING_MAX = 3'd5,
        CFG_STRING_TOL = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [LEN_W-1:0]   prism_max_len;
        logic [LEN_W-1:0]   prism_min_len;
        logic [LEN_W-1:0]   step_distance;
        logic [PAUSE_W-1:0] pause_limit;
        logic [SMIN_W-1:0]  string_min_goal;
        logic [SMAX_W-1:0]  string_max_goal;
        logic [STOL_W-1:0]  string_tolerance;
    } cfg_t;

    // last member first so the first field lands in the lowest bits
    typedef struct packed {
        logic [LEN_W-1:0] vert_len_3;
        logic [LEN_W-1:0] vert_len_2;
        logic [LEN_W-1:0] vert_len_1;
        logic [LEN_W-1:0] vert_len_0;
        logic             top_touch;
        logic             bottom_touch;
        logic [LEN_W-1:0] top_prism_len;
        logic [LEN_W-1:0] bottom_prism_len;
    } in_item_t;

    typedef struct packed {
        logic             phase_done;
        logic [LEN_W-1:0] vert_goal;
        logic [LEN_W-1:0] saddle_goal;
        logic             strings_active;
        logic [LEN_W-1:0] prism_cmd_len;
        logic             prism_is_top;
        logic             prism_cmd_valid;
        logic [2:0]       phase_now;
    } res_t;

    localparam int IN_BITS   = $bits(in_item_t);
    localparam int IN_BYTES  = (IN_BITS + 7) / 8;
    localparam int OUT_BITS  = $bits(res_t);
    localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

endpackage

// ===== hdl/six_phase_crawl_gait_sequencer_unit.sv =====
// six_phase_crawl_gait_sequencer_unit: top level of the crawl gait sequencer
// input register, configuration registers, cgs_step and result register
// depends on cgs_pkg and cgs_step
//
//   channel  dir  handshake          payload
//   s_       in   s_tvalid/s_tready  s_tdata  one sensor tick
//   m_       out  m_tvalid/m_tready  m_tdata  one gait command
//   cfg_     in   cfg_we             cfg_addr, cfg_wdata
//
// one beat per cycle sustained while m_tready stays high; an input beat passes the input register,
// then the gait logic into the result register
// reset is synchronous, active low; it clears phase, touch count and both valid flags and loads the
// configuration defaults; a stalled result holds the result register; the input register still takes
// a beat while the result register is full, then s_tready drops
module six_phase_crawl_gait_sequencer_unit #(
    parameter int NUM_VERT   = 4,
    parameter int ARRIVE_TOL = 26
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // bottom_prism_len, top_prism_len, bottom_touch, top_touch, vert_len_0..3
    input  logic [8*cgs_pkg::IN_BYTES-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // phase_now, prism_cmd_valid, prism_is_top, prism_cmd_len, strings_active,
    // saddle_goal, vert_goal, phase_done
    output logic [8*cgs_pkg::OUT_BYTES-1:0]    m_tdata,
    input  logic                               cfg_we,
    input  logic [cgs_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [cgs_pkg::CFG_DW-1:0]         cfg_wdata
);

    logic              s1_valid_reg, s1_valid_next;
    cgs_pkg::in_item_t s1_item_reg;
    logic              m_valid_reg, m_valid_next;
    cgs_pkg::res_t     m_res_reg;
    cgs_pkg::res_t     step_res;
    cgs_pkg::cfg_t     cfg_reg;
    logic              out_free, s1_adv, s_acc;

    assign out_free = !m_valid_reg || m_tready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign s_acc    = s_tvalid && s_tready;

    assign s1_valid_next = s_acc || (s1_valid_reg && !out_free);
    assign m_valid_next  = s1_adv || (m_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s1_item_reg <= cgs_pkg::in_item_t'(s_tdata[cgs_pkg::IN_BITS-1:0]);
        end
        if (s1_adv) begin
            m_res_reg <= step_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prism_max_len    <= cgs_pkg::RST_PRISM_MAX;
            cfg_reg.prism_min_len    <= cgs_pkg::RST_PRISM_MIN;
            cfg_reg.step_distance    <= cgs_pkg::RST_STEP;
            cfg_reg.pause_limit      <= cgs_pkg::RST_PAUSE;
            cfg_reg.string_min_goal  <= cgs_pkg::RST_SMIN;
            cfg_reg.string_max_goal  <= cgs_pkg::RST_SMAX;
            cfg_reg.string_tolerance <= cgs_pkg::RST_STOL;
        end else if (cfg_we) begin
            case (cgs_pkg::cfg_idx_t'(cfg_addr))
                cgs_pkg::CFG_PRISM_MAX: begin
                    cfg_reg.prism_max_len <= cfg_wdata;
                end
                cgs_pkg::CFG_PRISM_MIN: begin
                    cfg_reg.prism_min_len <= cfg_wdata;
                end
                cgs_pkg::CFG_STEP: begin
                    cfg_reg.step_distance <= cfg_wdata;
                end
                cgs_pkg::CFG_PAUSE: begin
                    cfg_reg.pause_limit <= cfg_wdata[cgs_pkg::PAUSE_W-1:0];
                end
                cgs_pkg::CFG_STRING_MIN: begin
                    cfg_reg.string_min_goal <= cfg_wdata[cgs_pkg::SMIN_W-1:0];
                end
                cgs_pkg::CFG_STRING_MAX: begin
                    cfg_reg.string_max_goal <= cfg_wdata[cgs_pkg::SMAX_W-1:0];
                end
                cgs_pkg::CFG_STRING_TOL: begin
                    cfg_reg.string_tolerance <= cfg_wdata[cgs_pkg::STOL_W-1:0];
                end
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    cgs_step #(
        .NUM_VERT   (NUM_VERT),
        .ARRIVE_TOL (ARRIVE_TOL)
    ) u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (s1_adv),
        .item    (s1_item_reg),
        .cfg     (cfg_reg),
        .res     (step_res)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(8*cgs_pkg::OUT_BYTES-cgs_pkg::OUT_BITS){1'b0}}, m_res_reg};

    a_in_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> s1_valid_reg)
        else $error("accepted beat not held in input register");

    a_no_bubble: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !m_valid_reg) |-> s1_adv)
        else $error("input register stalled with result register empty");

    a_adv_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_adv |=> m_valid_reg)
        else $error("computed result not presented");

    a_excl_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_adv && step_res.strings_active) |-> !step_res.prism_cmd_valid)
        else $error("prism command issued in a string phase");

endmodule

// ===== hdl/cgs_step.sv =====
// cgs_step: phase and touch counter state with the per-tick gait logic
// computes one result from one beat and the current state
// depends on cgs_pkg
module cgs_step #(
    parameter int NUM_VERT   = 4,
    parameter int ARRIVE_TOL = 26
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  cgs_pkg::in_item_t item,
    input  cgs_pkg::cfg_t     cfg,
    output cgs_pkg::res_t     res
);

    localparam int NV = (NUM_VERT < cgs_pkg::VERT_IN) ? NUM_VERT : cgs_pkg::VERT_IN;
    localparam logic [cgs_pkg::LEN_W-1:0] TOL = cgs_pkg::LEN_W'(ARRIVE_TOL);

    cgs_pkg::phase_t                 phase_reg, phase_next;
    logic [cgs_pkg::TOUCH_W-1:0]     touch_count_reg, touch_count_next;

    logic                            is_prism;
    logic [cgs_pkg::LEN_W-1:0]       cur, goal, cmd, absd, sgoal, vgoal, vdiff;
    logic                            touch, up, dn, arrive, hit, any_vert;
    logic [cgs_pkg::LEN_W:0]         up_sum;
    logic [cgs_pkg::TOUCH_W-1:0]     tc_inc;
    logic [cgs_pkg::LEN_W-1:0]       vlen [cgs_pkg::VERT_IN];

    // operand selection per phase
    always_comb begin
        is_prism = 1'b0;
        cur      = item.bottom_prism_len;
        goal     = cfg.prism_max_len;
        touch    = 1'b0;
        sgoal    = '0;
        vgoal    = '0;
        case (phase_reg)
            cgs_pkg::PH_EXPAND_BOTTOM: begin
                is_prism = 1'b1;
                touch    = item.bottom_touch;
            end
            cgs_pkg::PH_RETRACT_TOP: begin
                is_prism = 1'b1;
                cur      = item.top_prism_len;
                goal     = cfg.prism_min_len;
                touch    = item.top_touch;
            end
            cgs_pkg::PH_EXPAND_TOP: begin
                is_prism = 1'b1;
                cur      = item.top_prism_len;
                touch    = item.top_touch;
            end
            cgs_pkg::PH_RETRACT_BOTTOM: begin
                is_prism = 1'b1;
                goal     = cfg.prism_min_len;
                touch    = item.bottom_touch;
            end
            cgs_pkg::PH_PUSH_TOP: begin
                sgoal = cgs_pkg::LEN_W'(cfg.string_min_goal);
                vgoal = cgs_pkg::LEN_W'(cfg.string_max_goal);
            end
            cgs_pkg::PH_PULL_BOTTOM: begin
                sgoal = cgs_pkg::LEN_W'(cfg.string_max_goal);
                vgoal = cgs_pkg::LEN_W'(cfg.string_min_goal);
            end
            default: begin
                is_prism = 1'b0;
            end
        endcase
    end

    // prism command and arrival
    assign up     = goal > cur;
    assign dn     = goal < cur;
    assign up_sum = {1'b0, cur} + {1'b0, cfg.step_distance};
    assign absd   = up ? (goal - cur) : (cur - goal);
    assign arrive = absd < TOL;

    always_comb begin
        cmd = cur;
        if (up) begin
            cmd = up_sum[cgs_pkg::LEN_W] ? '1 : up_sum[cgs_pkg::LEN_W-1:0];
        end else if (dn) begin
            cmd = (cfg.step_distance > cur) ? '0 : (cur - cfg.step_distance);
        end
    end

    // shared touch counter
    assign tc_inc = (touch && (touch_count_reg < cgs_pkg::TOUCH_MAX))
                    ? touch_count_reg + 1'b1 : touch_count_reg;
    assign hit    = tc_inc > cgs_pkg::TOUCH_W'(cfg.pause_limit);

    // vertical string arrival
    assign vlen[0] = item.vert_len_0;
    assign vlen[1] = item.vert_len_1;
    assign vlen[2] = item.vert_len_2;
    assign vlen[3] = item.vert_len_3;

    always_comb begin
        any_vert = 1'b0;
        vdiff    = '0;
        for (int i = 0; i < cgs_pkg::VERT_IN; i++) begin
            if (i < NV) begin
                vdiff = (vlen[i] >= vgoal) ? (vlen[i] - vgoal) : (vgoal - vlen[i]);
                if (vdiff < cgs_pkg::LEN_W'(cfg.string_tolerance)) begin
                    any_vert = 1'b1;
                end
            end
        end
    end

    // next state
    always_comb begin
        phase_next       = phase_reg;
        touch_count_next = touch_count_reg;
        if (is_prism) begin
            touch_count_next = hit ? '0 : tc_inc;
        end
        case (phase_reg)
            cgs_pkg::PH_EXPAND_BOTTOM, cgs_pkg::PH_RETRACT_TOP,
            cgs_pkg::PH_EXPAND_TOP: begin
                if (arrive || hit) begin
                    phase_next = cgs_pkg::phase_t'(phase_reg + 3'd1);
                end
            end
            cgs_pkg::PH_RETRACT_BOTTOM: begin
                if (arrive || hit) begin
                    phase_next = cgs_pkg::PH_PULL_BOTTOM;
                end
            end
            cgs_pkg::PH_PUSH_TOP: begin
                if (any_vert) begin
                    phase_next = cgs_pkg::PH_EXPAND_TOP;
                end
            end
            cgs_pkg::PH_PULL_BOTTOM: begin
                if (any_vert) begin
                    phase_next = cgs_pkg::PH_EXPAND_BOTTOM;
                end
            end
            default: begin
                phase_next = cgs_pkg::PH_EXPAND_BOTTOM;
            end
        endcase
    end

    // result fields
    always_comb begin
        res           = '0;
        res.phase_now = phase_reg;
        case (phase_reg)
            cgs_pkg::PH_EXPAND_BOTTOM, cgs_pkg::PH_RETRACT_TOP,
            cgs_pkg::PH_EXPAND_TOP, cgs_pkg::PH_RETRACT_BOTTOM: begin
                res.prism_cmd_valid = up || dn;
                res.prism_is_top    = (phase_reg == cgs_pkg::PH_RETRACT_TOP) ||
                                      (phase_reg == cgs_pkg::PH_EXPAND_TOP);
                res.prism_cmd_len   = cmd;
                res.phase_done      = arrive || hit;
            end
            cgs_pkg::PH_PUSH_TOP, cgs_pkg::PH_PULL_BOTTOM: begin
                res.strings_active = 1'b1;
                res.saddle_goal    = sgoal;
                res.vert_goal      = vgoal;
                res.phase_done     = any_vert;
            end
            default: begin
                res.phase_done = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= cgs_pkg::PH_EXPAND_BOTTOM;
            touch_count_reg <= '0;
        end else if (adv) begin
            phase_reg       <= phase_next;
            touch_count_reg <= touch_count_next;
        end
    end

endmodule

// ===== tb/sv/gait_cmd_monitor.sv =====
// gait_cmd_monitor: watches the sensor, command and register ports of the crawl gait sequencer
// predicts each gait command from its own phase, touch count and register copies and compares
// depends on cgs_pkg
module gait_cmd_monitor
    import cgs_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [8*IN_BYTES-1:0]       s_tdata,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [8*OUT_BYTES-1:0]      m_tdata,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_addr,
    input  logic [CFG_DW-1:0]           cfg_wdata,
    output int                          fail_count,
    output int                          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_VERT   = 4;
    localparam int ARRIVE_TOL = 26;

    logic [LEN_W-1:0]   reach_max;
    logic [LEN_W-1:0]   reach_min;
    logic [LEN_W-1:0]   stride;
    logic [PAUSE_W-1:0] touch_limit;
    logic [SMIN_W-1:0]  saddle_short;
    logic [SMAX_W-1:0]  saddle_long;
    logic [STOL_W-1:0]  string_tol;
    logic [2:0]         gait_phase;
    logic [TOUCH_W-1:0] touch_ticks;

    res_t cmds_due[$];
    res_t want;
    res_t got;

    function automatic bit prism_step(input logic [LEN_W-1:0] cur, input logic [LEN_W-1:0] goal,
                                      input logic touch, inout res_t r);
        logic [LEN_W:0]   up;
        logic [LEN_W-1:0] gap;
        bit               hit;
        hit = 0;
        if (goal > cur) begin
            up = {1'b0, cur} + {1'b0, stride};
            r.prism_cmd_len = up[LEN_W] ? '1 : up[LEN_W-1:0];
            gap = goal - cur;
        end else if (goal < cur) begin
            r.prism_cmd_len = (stride > cur) ? '0 : cur - stride;
            gap = cur - goal;
        end else begin
            r.prism_cmd_len = cur;
            gap = '0;
        end
        r.prism_cmd_valid = (goal != cur);
        if (touch && touch_ticks != TOUCH_MAX)
            touch_ticks = touch_ticks + 1'b1;
        if (touch_ticks > touch_limit) begin
            touch_ticks = '0;
            hit = 1;
        end
        return (int'(gap) < ARRIVE_TOL) || hit;
    endfunction

    function automatic bit string_step(input in_item_t it, input logic [LEN_W-1:0] sgoal,
                                       input logic [LEN_W-1:0] vgoal, inout res_t r);
        logic [LEN_W-1:0] verts [4];
        int               d;
        bit               any;
        verts = '{it.vert_len_0, it.vert_len_1, it.vert_len_2, it.vert_len_3};
        any = 0;
        r.strings_active = 1'b1;
        r.saddle_goal = sgoal;
        r.vert_goal = vgoal;
        for (int i = 0; i < NUM_VERT && i < 4; i++) begin
            d = int'(verts[i]) - int'(vgoal);
            if (d < 0)
                d = -d;
            if (d < int'(string_tol))
                any = 1;
        end
        return any;
    endfunction

    function automatic res_t next_gait_cmd(input in_item_t it);
        res_t r;
        bit   done;
        r = '0;
        r.phase_now = gait_phase;
        done = 0;
        case (gait_phase)
            PH_EXPAND_BOTTOM: begin
                done = prism_step(it.bottom_prism_len, reach_max, it.bottom_touch, r);
            end
            PH_RETRACT_TOP: begin
                r.prism_is_top = 1'b1;
                done = prism_step(it.top_prism_len, reach_min, it.top_touch, r);
            end
            PH_PUSH_TOP: begin
                done = string_step(it, LEN_W'(saddle_short), LEN_W'(saddle_long), r);
            end
            PH_EXPAND_TOP: begin
                r.prism_is_top = 1'b1;
                done = prism_step(it.top_prism_len, reach_max, it.top_touch, r);
            end
            PH_RETRACT_BOTTOM: begin
                done = prism_step(it.bottom_prism_len, reach_min, it.bottom_touch, r);
            end
            PH_PULL_BOTTOM: begin
                done = string_step(it, LEN_W'(saddle_long), LEN_W'(saddle_short), r);
            end
            default: begin
                gait_phase = PH_EXPAND_BOTTOM;
                r.phase_done = 1'b1;
                return r;
            end
        endcase
        if (done) begin
            gait_phase = (gait_phase >= PH_PULL_BOTTOM) ? PH_EXPAND_BOTTOM : gait_phase + 3'd1;
            r.phase_done = 1'b1;
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [LEN_W-1:0] exp_val,
                                        input logic [LEN_W-1:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            reach_max    <= RST_PRISM_MAX;
            reach_min    <= RST_PRISM_MIN;
            stride       <= RST_STEP;
            touch_limit  <= RST_PAUSE;
            saddle_short <= RST_SMIN;
            saddle_long  <= RST_SMAX;
            string_tol   <= RST_STOL;
            gait_phase   = PH_EXPAND_BOTTOM;
            touch_ticks  = '0;
            fail_count   = 0;
            cmds_due.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_PRISM_MAX:  reach_max    <= cfg_wdata[LEN_W-1:0];
                    CFG_PRISM_MIN:  reach_min    <= cfg_wdata[LEN_W-1:0];
                    CFG_STEP:       stride       <= cfg_wdata[LEN_W-1:0];
                    CFG_PAUSE:      touch_limit  <= cfg_wdata[PAUSE_W-1:0];
                    CFG_STRING_MIN: saddle_short <= cfg_wdata[SMIN_W-1:0];
                    CFG_STRING_MAX: saddle_long  <= cfg_wdata[SMAX_W-1:0];
                    CFG_STRING_TOL: string_tol   <= cfg_wdata[STOL_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                cmds_due.push_back(next_gait_cmd(in_item_t'(s_tdata[IN_BITS-1:0])));
            if (m_tvalid && m_tready) begin
                got = res_t'(m_tdata[OUT_BITS-1:0]);
                if (cmds_due.size() == 0) begin
                    $error("command beat with nothing expected: %h", m_tdata);
                    fail_count++;
                end else begin
                    want = cmds_due.pop_front();
                    check_field("phase_now", want.phase_now, got.phase_now);
                    check_field("prism_cmd_valid", want.prism_cmd_valid, got.prism_cmd_valid);
                    check_field("prism_is_top", want.prism_is_top, got.prism_is_top);
                    check_field("prism_cmd_len", want.prism_cmd_len, got.prism_cmd_len);
                    check_field("strings_active", want.strings_active, got.strings_active);
                    check_field("saddle_goal", want.saddle_goal, got.saddle_goal);
                    check_field("vert_goal", want.vert_goal, got.vert_goal);
                    check_field("phase_done", want.phase_done, got.phase_done);
                end
            end
        end
        pending = cmds_due.size();
    end

endmodule

// ===== tb/sv/six_phase_crawl_gait_sequencer_unit_tb.sv =====
// six_phase_crawl_gait_sequencer_unit_tb: drives sensor ticks and register writes into the
// crawl gait sequencer with random stalls on both sides bar last two segments; reports verdict
// depends on cgs_pkg, gait_cmd_monitor and six_phase_crawl_gait_sequencer_unit
module six_phase_crawl_gait_sequencer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cgs_pkg::*;

    localparam int STALL_LIMIT   = 5000;
    localparam int TICKS_PER_SEG = 180;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [8*IN_BYTES-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [8*OUT_BYTES-1:0] m_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_addr = '0;
    logic [CFG_DW-1:0]      cfg_wdata = '0;

    int fail_count;
    int pending;
    int send_idle_pct = 38;
    int recv_idle_pct = 81;
    int stall_run = 0;

    logic [LEN_W-1:0]   lim_max = RST_PRISM_MAX;
    logic [LEN_W-1:0]   lim_min = RST_PRISM_MIN;
    logic [SMIN_W-1:0]  smin_goal = RST_SMIN;
    logic [SMAX_W-1:0]  smax_goal = RST_SMAX;
    logic [STOL_W-1:0]  stol = RST_STOL;

    six_phase_crawl_gait_sequencer_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    gait_cmd_monitor mon (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        stall_run <= ((s_tvalid && s_tready) || (m_tvalid && m_tready)) ? 0 : stall_run + 1;
    end

    initial begin
        while (stall_run < STALL_LIMIT)
            @(posedge aclk);
        $display("** six_phase_crawl_gait_sequencer_unit: FAILED **");
        $finish;
    end

    function automatic logic [LEN_W-1:0] clamp_len(input int v);
        if (v < 0)
            return '0;
        if (v > 65535)
            return '1;
        return LEN_W'(v);
    endfunction

    // half near the prism goals so phases finish, the rest at the extremes or anywhere
    function automatic logic [LEN_W-1:0] prism_sample();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1:    return clamp_len(int'(lim_max) + int'($urandom_range(0, 80)) - 40);
            2, 3:    return clamp_len(int'(lim_min) + int'($urandom_range(0, 80)) - 40);
            4:       return $urandom_range(0, 1) ? lim_max : lim_min;
            5:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: return LEN_W'($urandom());
        endcase
    endfunction

    // mostly straddles the string tolerance window around either goal, the rest anywhere
    function automatic logic [LEN_W-1:0] vert_sample();
        int pick;
        int span;
        span = int'(stol) + 2;
        pick = $urandom_range(0, 5);
        case (pick)
            0, 1:    return clamp_len(int'(smax_goal) + int'($urandom_range(0, 2 * span)) - span);
            2, 3:    return clamp_len(int'(smin_goal) + int'($urandom_range(0, 2 * span)) - span);
            default: return LEN_W'($urandom());
        endcase
    endfunction

    function automatic in_item_t tick(input logic [LEN_W-1:0] blen, input logic [LEN_W-1:0] tlen,
                                      input logic btouch, input logic ttouch,
                                      input logic [LEN_W-1:0] v0, input logic [LEN_W-1:0] v1,
                                      input logic [LEN_W-1:0] v2, input logic [LEN_W-1:0] v3);
        in_item_t it;
        it.bottom_prism_len = blen;
        it.top_prism_len    = tlen;
        it.bottom_touch     = btouch;
        it.top_touch        = ttouch;
        it.vert_len_0       = v0;
        it.vert_len_1       = v1;
        it.vert_len_2       = v2;
        it.vert_len_3       = v3;
        return it;
    endfunction

    task automatic send_tick(input in_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(8*IN_BYTES-IN_BITS){1'b0}}, it};
        do
            @(posedge aclk);
        while (!s_tready);
    endtask

    // drops s_tvalid and lets the monitor count the last accepted beat as pending before polling
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input int val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= CFG_DW'(val);
        @(posedge aclk);
    endtask

    task automatic load_cfg(input int pmax, input int pmin, input int step, input int pause,
                            input int smin, input int smax, input int tol);
        write_reg(CFG_PRISM_MAX, pmax);
        write_reg(CFG_PRISM_MIN, pmin);
        write_reg(CFG_STEP, step);
        write_reg(CFG_PAUSE, pause);
        write_reg(CFG_STRING_MIN, smin);
        write_reg(CFG_STRING_MAX, smax);
        write_reg(CFG_STRING_TOL, tol);
        cfg_we    <= 1'b0;
        lim_max   = LEN_W'(pmax);
        lim_min   = LEN_W'(pmin);
        smin_goal = SMIN_W'(smin);
        smax_goal = SMAX_W'(smax);
        stol      = STOL_W'(tol);
        @(posedge aclk);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // walk one full gait on reset registers, hitting the step and window edges
        send_tick(tick(16'h0000, 16'hFFFF, 1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_tick(tick(16'hFFFF, 16'h0000, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_tick(tick(16'd5094, 16'd0, 1'b0, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0));
        send_tick(tick(16'd5145, 16'd0, 1'b1, 1'b0, 16'd2560, 16'd2560, 16'd2560, 16'd2560));
        send_tick(tick(16'd0, 16'hFFFF, 1'b0, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0));
        send_tick(tick(16'd0, 16'h0000, 1'b1, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0));
        send_tick(tick(16'd0, 16'd1306, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0));
        send_tick(tick(16'd0, 16'd1280, 1'b0, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0));
        send_tick(tick(16'd0, 16'd0, 1'b1, 1'b1, 16'd2816, 16'd2304, 16'd0, 16'hFFFF));
        send_tick(tick(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 16'd2304, 16'd2816, 16'd0, 16'd2815));
        send_tick(tick(16'd0, 16'd5095, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0));
        send_tick(tick(16'd1306, 16'd0, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0));
        send_tick(tick(16'd1280, 16'd0, 1'b0, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0));
        send_tick(tick(16'd0, 16'd0, 1'b0, 1'b0, 16'd2560, 16'd1536, 16'd1024, 16'hFFFF));
        send_tick(tick(16'd0, 16'd0, 1'b0, 1'b0, 16'hFFFF, 16'd1025, 16'd0, 16'd0));
        send_tick(tick(16'd0, 16'd0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0));
        send_tick(tick(16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));

        for (int seg = 0; seg < 6; seg++) begin
            settle();
            case (seg / 2)
                0: begin
                    send_idle_pct <= 38;
                    recv_idle_pct <= 81;
                end
                1: begin
                    send_idle_pct <= 81;
                    recv_idle_pct <= 38;
                end
                default: begin
                    send_idle_pct <= 0;
                    recv_idle_pct <= 0;
                end
            endcase
            case (seg)
                0: load_cfg(65535, 0, 65535, 2000, 2560, 5120, 1280);
                1: load_cfg(0, 65535, 0, 0, 0, 1280, 0);
                2: load_cfg(RST_PRISM_MAX, RST_PRISM_MIN, RST_STEP, RST_PAUSE,
                            RST_SMIN, RST_SMAX, RST_STOL);
                3: load_cfg($urandom_range(0, 65535), $urandom_range(0, 65535),
                            $urandom_range(0, 1024), $urandom_range(0, 8),
                            $urandom_range(0, 2560), $urandom_range(1280, 5120),
                            $urandom_range(0, 1280));
                4: load_cfg($urandom_range(0, 65535), $urandom_range(0, 65535),
                            $urandom_range(0, 65535), $urandom_range(0, 2000),
                            $urandom_range(0, 2560), $urandom_range(1280, 5120),
                            $urandom_range(0, 1280));
                default: load_cfg($urandom_range(0, 65535), $urandom_range(0, 65535),
                                  $urandom_range(0, 300), $urandom_range(0, 3),
                                  $urandom_range(0, 2560), $urandom_range(1280, 5120),
                                  $urandom_range(1, 1280));
            endcase
            for (int n = 0; n < TICKS_PER_SEG; n++) begin
                send_tick(tick(prism_sample(), prism_sample(),
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               vert_sample(), vert_sample(), vert_sample(), vert_sample()));
            end
        end

        settle();
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("** six_phase_crawl_gait_sequencer_unit: PASSED **");
        else
            $display("** six_phase_crawl_gait_sequencer_unit: FAILED **");
        $finish;
    end

endmodule
